// ----- hw/rtl/windowed_peak_to_mean_motion_detector_assert.svh -----
// Assertion macros shared by the peak-to-mean motion detector RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef WINDOWED_PEAK_TO_MEAN_MOTION_DETECTOR_ASSERT_SVH
`define WINDOWED_PEAK_TO_MEAN_MOTION_DETECTOR_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define WPMD_PROP(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define WPMD_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/wpmd_pkg.sv -----
// Shared types and constants for the windowed peak-to-mean motion detector.
// No dependencies; every RTL module imports this package.
`timescale 1ns / 1ps
`default_nettype none

package wpmd_pkg;

  localparam int CHANNELS    = 5;
  localparam int SAMPLE_BITS = 12;
  localparam int MAX_WINDOW  = 1024;
  localparam int LEN_W       = 11;
  localparam int SUM_W       = 22;
  localparam int THRESH_W    = 16;
  localparam int CFG_W       = 16;
  localparam int RATIO_W     = 19;
  localparam int QUO_W       = 19;
  localparam int PROD_W      = 23;
  localparam int TOTAL_W     = 21;
  localparam int CHAN_W      = 3;
  localparam int STEP_W      = 5;
  localparam int QUEUE_DEPTH = 2;

  // floor(x / 5) == (x * RECIP5) >> RECIP_SHIFT for every x below 2^22
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 23;
  localparam logic [RECIP_W-1:0] RECIP5 = 21'd1677722;

  localparam logic [LEN_W-1:0]    WINDOW_RESET    = 11'd512;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd282;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [CHANNELS-1:0] sample_vec_t;

  // One finished window as handed from the accumulator to the ratio engine.
  typedef struct packed {
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] peaks;
    logic [CHANNELS-1:0][SUM_W-1:0]       sums;
    logic [LEN_W-1:0]                     len;
  } window_t;

  typedef enum logic {
    REG_WINDOW_LENGTH   = 1'b0,
    REG_RATIO_THRESHOLD = 1'b1
  } reg_index_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wpmd_front.sv -----
// Front end: accepts sample transactions, keeps per-channel sums and peaks,
// and pushes a window snapshot when the window closes. Uses wpmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpmd_front (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       sample_valid,
  output logic                      sample_stall,
  input  wpmd_pkg::sample_vec_t     samples,
  input  wire [wpmd_pkg::LEN_W-1:0] window_length,
  input  wire                       queue_full,
  output logic                      push,
  output wpmd_pkg::window_t         snapshot
);
  import wpmd_pkg::*;

  logic [CHANNELS-1:0][SUM_W-1:0]       sums;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] peaks;
  logic [LEN_W-1:0]                     count;

  logic [CHANNELS-1:0][SUM_W-1:0]       sums_next;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] peaks_next;
  logic [LEN_W-1:0]                     count_next;
  logic [LEN_W-1:0]                     len_eff;
  logic                                 accept;
  logic                                 window_end;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      sums_next[c]  = sums[c] + SUM_W'(samples[c]);
      peaks_next[c] = (samples[c] > peaks[c]) ? samples[c] : peaks[c];
    end
    // zero means one sample per window; beyond the maximum saturates
    if (window_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (window_length > LEN_W'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = window_length;
    end
    count_next = count + LEN_W'(1);
    // >= so a length lowered mid-window closes on the next sample
    window_end = (count_next >= len_eff);
  end

  assign sample_stall   = queue_full;
  assign accept         = sample_valid && !queue_full;
  assign push           = accept && window_end;
  assign snapshot.peaks = peaks_next;
  assign snapshot.sums  = sums_next;
  assign snapshot.len   = len_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      sums  <= '0;
      peaks <= '0;
      count <= '0;
    end else if (accept) begin
      if (window_end) begin
        sums  <= '0;
        peaks <= '0;
        count <= '0;
      end else begin
        sums  <= sums_next;
        peaks <= peaks_next;
        count <= count_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/wpmd_queue.sv -----
// Two-entry queue of window snapshots between the front end and the ratio engine.
// Uses wpmd_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "windowed_peak_to_mean_motion_detector_assert.svh"

module wpmd_queue (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  wpmd_pkg::window_t push_data,
  output logic              full,
  input  wire               pop,
  output logic              head_valid,
  output wpmd_pkg::window_t head
);
  import wpmd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  window_t                entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [PTR_W:0]         count;

  logic                   do_push;
  logic                   do_pop;

  assign full       = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

  `WPMD_PROP(a_queue_bound, count <= (PTR_W+1)'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

// ----- hw/rtl/wpmd_back.sv -----
// Ratio engine: per channel floor(peak*N*256/sum) by a serial divider,
// then average over the channels and threshold. Uses wpmd_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "windowed_peak_to_mean_motion_detector_assert.svh"

module wpmd_back (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          head_valid,
  input  wpmd_pkg::window_t            head,
  output logic                         pop,
  input  wire [wpmd_pkg::THRESH_W-1:0] ratio_threshold,
  output logic                         result_valid,
  input  wire                          result_stall,
  output logic [wpmd_pkg::RATIO_W-1:0] mean_ratio,
  output logic                         motion_detected
);
  import wpmd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_DIV    = 6'b000100,
    S_ACC    = 6'b001000,
    S_SCALE  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t                          state;
  logic [CHAN_W-1:0]               chan;
  logic [STEP_W-1:0]               step;
  logic [SUM_W-1:0]                rem;
  logic [SUM_W-1:0]                divisor;
  logic [QUO_W-1:0]                quo;
  logic                            zero_sum;
  logic [TOTAL_W-1:0]              total;
  logic [TOTAL_W+RECIP_W-1:0]      scaled;

  logic [PROD_W-1:0]               product;
  logic [SUM_W+1:0]                trial;
  logic                            borrow;
  logic [RATIO_W-1:0]              avg;
  logic                            load;

  assign product = PROD_W'(head.peaks[chan]) * PROD_W'(head.len);
  // restoring step: bring down the next numerator bit, try to subtract
  assign trial   = {1'b0, rem, quo[QUO_W-1]} - {2'b00, divisor};
  assign borrow  = trial[SUM_W+1];
  assign avg     = scaled[RECIP_SHIFT +: RATIO_W];
  assign load    = (state == S_FINISH) && (!result_valid || !result_stall);
  assign pop     = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chan  <= '0;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            chan  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          step  <= '0;
          state <= (head.sums[chan] == '0) ? S_ACC : S_DIV;
        end
        S_DIV: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(QUO_W-1)) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (chan == CHAN_W'(CHANNELS-1)) begin
            state <= S_SCALE;
          end else begin
            chan  <= chan + CHAN_W'(1);
            state <= S_MUL;
          end
        end
        S_SCALE: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        total <= '0;
      end
      S_MUL: begin
        // quotient fits 19 bits, so the top numerator bits start below the divisor
        rem      <= SUM_W'(product[PROD_W-1:QUO_W-8]);
        quo      <= {product[QUO_W-9:0], 8'b0};
        divisor  <= head.sums[chan];
        zero_sum <= (head.sums[chan] == '0);
      end
      S_DIV: begin
        rem <= borrow ? SUM_W'({rem, quo[QUO_W-1]}) : trial[SUM_W-1:0];
        quo <= {quo[QUO_W-2:0], !borrow};
      end
      S_ACC: begin
        total <= total + (zero_sum ? '0 : TOTAL_W'(quo));
      end
      S_SCALE: begin
        scaled <= TOTAL_W'(total) * (TOTAL_W+RECIP_W)'(RECIP5);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mean_ratio      <= avg;
      motion_detected <= (avg > RATIO_W'(ratio_threshold));
    end
  end

  `WPMD_PROP(a_pop_has_head, pop |-> head_valid, "pop with empty queue")
  `WPMD_PROP(a_ratio_bound, (state == S_ACC && !zero_sum) |-> (quo <= {head.len, 8'b0}), "channel ratio above N*256")
  `WPMD_NEXT(a_hold_result, (state == S_FINISH && result_valid && result_stall), state == S_FINISH, "result overwritten under stall")

endmodule

`default_nettype wire

// ----- hw/rtl/windowed_peak_to_mean_motion_detector.sv -----
// Windowed peak-to-mean motion detector: configuration registers plus the
// front end, snapshot queue and ratio engine. Uses wpmd_pkg.
//
// Usage:
//   Sample channel: one transaction carries a 12-bit sample from each of the
//   four ADCs and the accelerometer. It is taken on a clock edge with
//   sample_valid high and sample_stall low. The front end takes one sample a
//   cycle; it stalls only when two closed windows are still waiting.
//   Result channel: one transaction per closed window with mean_ratio (Q.8
//   average peak/mean) and motion_detected (mean_ratio > ratio_threshold).
//   Processing: per channel the ratio engine multiplies, runs 19 divider
//   steps and accumulates, then scales the total and registers the result.
//   With the default 512-sample window the block keeps up with one sample per
//   cycle while result_stall is low; with short windows the engine, taking a
//   new window only after finishing the last, limits throughput. Result
//   register: a finished result waits there under result_stall while the
//   front end keeps accumulating the next window. Config: write_enable,
//   register_index, write_data; user writes only while idle; not enforced.
//   Reset: synchronous; clears sums, peaks, count, queue and result valid,
//   and loads window_length = 512, ratio_threshold = 282 (about 1.1 in Q8.8).
`timescale 1ns / 1ps
`default_nettype none

module windowed_peak_to_mean_motion_detector (
  input  wire                             clk,
  input  wire                             rst,
  // sample channel
  input  wire                             sample_valid,
  output logic                            sample_stall,
  input  wire [wpmd_pkg::SAMPLE_BITS-1:0] adc_one_sample,
  input  wire [wpmd_pkg::SAMPLE_BITS-1:0] adc_two_sample,
  input  wire [wpmd_pkg::SAMPLE_BITS-1:0] adc_three_sample,
  input  wire [wpmd_pkg::SAMPLE_BITS-1:0] adc_four_sample,
  input  wire [wpmd_pkg::SAMPLE_BITS-1:0] accel_sample,
  // result channel
  output logic                            result_valid,
  input  wire                             result_stall,
  output logic [wpmd_pkg::RATIO_W-1:0]    mean_ratio,
  output logic                            motion_detected,
  // configuration write port
  input  wire                             write_enable,
  input  wpmd_pkg::reg_index_t            register_index,
  input  wire [wpmd_pkg::CFG_W-1:0]       write_data
);
  import wpmd_pkg::*;

  logic [LEN_W-1:0]    window_length;
  logic [THRESH_W-1:0] ratio_threshold;

  sample_vec_t         samples;
  window_t             snapshot;
  window_t             head;
  logic                push;
  logic                queue_full;
  logic                pop;
  logic                head_valid;

  // Config registers: no read-back, plain writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length   <= WINDOW_RESET;
      ratio_threshold <= THRESHOLD_RESET;
    end else if (write_enable) begin
      case (register_index)
        REG_WINDOW_LENGTH:   window_length   <= write_data[LEN_W-1:0];
        REG_RATIO_THRESHOLD: ratio_threshold <= write_data[THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // channel order: four ADCs, then the accelerometer
  assign samples[0] = adc_one_sample;
  assign samples[1] = adc_two_sample;
  assign samples[2] = adc_three_sample;
  assign samples[3] = adc_four_sample;
  assign samples[4] = accel_sample;

  wpmd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .samples       (samples),
    .window_length (window_length),
    .queue_full    (queue_full),
    .push          (push),
    .snapshot      (snapshot)
  );

  // closed windows wait here so accumulation waits on the divider only when the queue is full
  wpmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (snapshot),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  wpmd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .ratio_threshold (ratio_threshold),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .mean_ratio      (mean_ratio),
    .motion_detected (motion_detected)
  );

endmodule

`default_nettype wire
